>>> sv/prbs9_chk_pkg.sv
// ----------------------------------------------------------------------------
// PRBS9 checker package
// Shared item, result and status types plus register indexes and constants.
// ----------------------------------------------------------------------------
package prbs9_chk_pkg;

   localparam int unsigned LFSR_W      = 9;
   localparam int unsigned COUNT_W     = 16;
   localparam int unsigned TOTAL_W     = 32;
   localparam int unsigned WARMUP_W    = 8;
   localparam int unsigned CSR_ADDR_W  = 8;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam int unsigned REQ_DATA_W  = 16;
   localparam int unsigned RSP_DATA_W  = 80;

   localparam int unsigned TAP_LOW     = 4;
   localparam int unsigned TAP_HIGH    = 8;

   localparam logic [COUNT_W-1:0]    MAX_BLOCK_BITS     = 16'd65535;
   localparam logic [COUNT_W-1:0]    BLOCK_LENGTH_RESET = 16'd1024;
   localparam logic [WARMUP_W-1:0]   WARMUP_RESET       = 8'd10;

   localparam logic [CSR_ADDR_W-1:0] REG_BLOCK_LENGTH  = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WARMUP_BLOCKS = 8'd1;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_BIT   = 1'b1;

   typedef struct packed {
      logic              func;
      logic [LFSR_W-1:0] seed;
      logic              rx_bit;
   } item_type;

   typedef struct packed {
      logic [TOTAL_W-1:0] blocks_counted;
      logic [TOTAL_W-1:0] total_errors;
      logic               counted;
      logic [COUNT_W-1:0] block_errors;
   } result_type;

   typedef struct packed {
      logic main_valid;
      logic skid_valid;
   } ibuf_stat_type;

endpackage

>>> sv/prbs9_chk_ibuf.sv
// ----------------------------------------------------------------------------
// PRBS9 checker input buffer
// Two-entry skid buffer; the upstream ready comes straight from a register.
// ----------------------------------------------------------------------------
module prbs9_chk_ibuf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  prbs9_chk_pkg::item_type  in_item,
   output logic                     head_valid,
   output prbs9_chk_pkg::item_type  head_item,
   input  logic                     head_take,
   output prbs9_chk_pkg::ibuf_stat_type stat
);
   import prbs9_chk_pkg::*;

   logic     main_valid_ff, main_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   item_type main_ff, main_in;
   item_type skid_ff, skid_in;
   logic     accept;
   logic     pop;

   assign in_ready = !skid_valid_ff;
   assign accept   = in_valid && !skid_valid_ff;
   assign pop      = main_valid_ff && head_take;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!main_valid_ff || pop) begin
            main_in       = in_item;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_item;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign head_valid      = main_valid_ff;
   assign head_item       = main_ff;
   assign stat.main_valid = main_valid_ff;
   assign stat.skid_valid = skid_valid_ff;

endmodule

>>> sv/prbs9_chk_core.sv
// ----------------------------------------------------------------------------
// PRBS9 checker core
// LFSR step, compare, block counting, totals and the result register.
// ----------------------------------------------------------------------------
module prbs9_chk_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_we,
   input  logic [prbs9_chk_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [prbs9_chk_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                                   head_valid,
   input  prbs9_chk_pkg::item_type                head_item,
   output logic                                   head_take,
   output logic                                   out_valid,
   output prbs9_chk_pkg::result_type              out_result,
   input  logic                                   out_ready
);
   import prbs9_chk_pkg::*;

   logic [COUNT_W-1:0]  block_length_ff, block_length_in;
   logic [LFSR_W-1:0]   lfsr_ff, lfsr_in;
   logic [COUNT_W-1:0]  pos_ff, pos_in;
   logic [COUNT_W-1:0]  errs_ff, errs_in;
   logic [WARMUP_W-1:0] warmup_left_ff, warmup_left_in;
   logic [TOTAL_W-1:0]  err_total_ff, err_total_in;
   logic [TOTAL_W-1:0]  blk_total_ff, blk_total_in;
   logic                out_valid_ff, out_valid_in;
   result_type          result_ff, result_in;

   logic                ref_bit;
   logic [COUNT_W-1:0]  pos_next;
   logic [COUNT_W-1:0]  errs_next;
   logic [COUNT_W-1:0]  eff_len;
   logic                is_bit;
   logic                done;
   logic                out_free;
   logic [TOTAL_W:0]    err_sum;

   assign ref_bit   = lfsr_ff[TAP_LOW] ^ lfsr_ff[TAP_HIGH];
   assign pos_next  = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign errs_next = ((ref_bit != head_item.rx_bit) && (errs_ff != '1)) ?
                      errs_ff + 1'b1 : errs_ff;

   always_comb begin
      if (block_length_ff == '0) begin
         eff_len = {{(COUNT_W-1){1'b0}}, 1'b1};
      end else if (block_length_ff > MAX_BLOCK_BITS) begin
         eff_len = MAX_BLOCK_BITS;
      end else begin
         eff_len = block_length_ff;
      end
   end

   assign is_bit    = (head_item.func == FUNC_BIT);
   assign done      = is_bit && (pos_next >= eff_len);
   assign out_free  = !out_valid_ff || out_ready;
   assign head_take = head_valid && (!done || out_free);
   assign err_sum   = {1'b0, err_total_ff} + {{(TOTAL_W-COUNT_W+1){1'b0}}, errs_next};

   always_comb begin
      block_length_in = block_length_ff;
      lfsr_in         = lfsr_ff;
      pos_in          = pos_ff;
      errs_in         = errs_ff;
      warmup_left_in  = warmup_left_ff;
      err_total_in    = err_total_ff;
      blk_total_in    = blk_total_ff;
      out_valid_in    = out_valid_ff && !out_ready;
      result_in       = result_ff;

      if (head_take) begin
         if (!is_bit) begin
            lfsr_in = head_item.seed;
            pos_in  = '0;
            errs_in = '0;
         end else begin
            lfsr_in = {lfsr_ff[LFSR_W-2:0], ref_bit};
            pos_in  = pos_next;
            errs_in = errs_next;
            if (done) begin
               result_in.block_errors = errs_next;
               if (warmup_left_ff != '0) begin
                  warmup_left_in    = warmup_left_ff - 1'b1;
                  result_in.counted = 1'b0;
               end else begin
                  err_total_in      = err_sum[TOTAL_W] ? '1 : err_sum[TOTAL_W-1:0];
                  blk_total_in      = (blk_total_ff == '1) ? blk_total_ff :
                                      blk_total_ff + 1'b1;
                  result_in.counted = 1'b1;
               end
               result_in.total_errors   = err_total_in;
               result_in.blocks_counted = blk_total_in;
               out_valid_in             = 1'b1;
               pos_in                   = '0;
               errs_in                  = '0;
            end
         end
      end

      if (csr_we) begin
         unique case (csr_addr)
            REG_BLOCK_LENGTH:  block_length_in = csr_wdata;
            REG_WARMUP_BLOCKS: warmup_left_in  = csr_wdata[WARMUP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_length_ff <= BLOCK_LENGTH_RESET;
         lfsr_ff         <= '0;
         pos_ff          <= '0;
         errs_ff         <= '0;
         warmup_left_ff  <= WARMUP_RESET;
         err_total_ff    <= '0;
         blk_total_ff    <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         block_length_ff <= block_length_in;
         lfsr_ff         <= lfsr_in;
         pos_ff          <= pos_in;
         errs_ff         <= errs_in;
         warmup_left_ff  <= warmup_left_in;
         err_total_ff    <= err_total_in;
         blk_total_ff    <= blk_total_in;
         out_valid_ff    <= out_valid_in;
      end
      result_ff <= result_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_result = result_ff;

endmodule

>>> sv/prbs9_bit_error_checker_unit.sv
// ----------------------------------------------------------------------------
// PRBS9 bit error checker
// Checks received bits against x^9+x^5+1 and reports per-block error counts.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = func (0 starts a block and loads the seed,
//   1 carries one received bit); tdata = seed[8:0], rx_bit[9].
//   rsp channel: one item at the end of each block with the block error
//   count, the counted flag and the saturating totals.
//   csr port: index 0 block_length, index 1 warmup_blocks (also restarts the
//   warm-up). Write only while no item is in flight.
// Timing:
//   One item per cycle unless a block-ending item waits on a held result.
//   Items are registered in the input buffer, results in the result
//   register. The LFSR step and compare are combinational. req_tready
//   comes from a register of the two-entry input skid buffer.
// Reset:
//   Sync, active high: block_length 1024, warm-up 10, LFSR, counters and
//   totals zero, both channels empty.
// Stall:
//   While rsp_tready is low a result is held; bit items without a result
//   keep flowing, and the input buffer fills before req_tready drops.
// ----------------------------------------------------------------------------
module prbs9_bit_error_checker_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [prbs9_chk_pkg::REQ_DATA_W-1:0]  req_tdata,  // seed[8:0], rx_bit[9], zeros
   input  logic                                  req_tuser,  // func
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [prbs9_chk_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // block_errors, total_errors, blocks_counted
   output logic                                  rsp_tuser,  // counted
   input  logic                                  csr_we,
   input  logic [prbs9_chk_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [prbs9_chk_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import prbs9_chk_pkg::*;

   item_type      in_item;
   item_type      head_item;
   logic          head_valid;
   logic          head_take;
   result_type    result;
   ibuf_stat_type ibuf_stat;

   assign in_item.func   = req_tuser;
   assign in_item.seed   = req_tdata[LFSR_W-1:0];
   assign in_item.rx_bit = req_tdata[LFSR_W];

   prbs9_chk_ibuf u_ibuf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_item    (in_item),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_take  (head_take),
      .stat       (ibuf_stat)
   );

   prbs9_chk_core u_core (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_take  (head_take),
      .out_valid  (rsp_tvalid),
      .out_result (result),
      .out_ready  (rsp_tready)
   );

   assign rsp_tdata = {result.blocks_counted, result.total_errors, result.block_errors};
   assign rsp_tuser = result.counted;

`ifndef SYNTHESIS
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      ibuf_stat.skid_valid |-> ibuf_stat.main_valid)
      else $error("skid entry held while main entry empty");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[79:48] != 32'd0)
      else $error("counted block reports zero blocks_counted");

   a_blocks_monotonic: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready ##1 rsp_tvalid |->
         rsp_tdata[79:48] >= $past(rsp_tdata[79:48]))
      else $error("blocks_counted went backwards");
`endif

endmodule
